// ===== hdl/qgap_pkg.sv =====
// ----------------------------------------------------------------------------
// qgap_pkg
// Shared types and constants of the quantized global average pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qgap_pkg;

    // lane geometry
    localparam int LANES        = 7;
    localparam int MAX_CHANNELS = 7;
    localparam int CNT_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int SUM_W        = 32;
    localparam int PROD_W       = 64;
    localparam int RND_W        = 63;
    localparam int SHIFT_W      = 6;
    localparam int ZP_W         = 16;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // queue depths
    localparam int MQ_DEPTH  = 2;
    localparam int MQ_AW     = $clog2(MQ_DEPTH);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // requantizer pipeline stages
    localparam int PIPE_N = 6;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_CHANNEL_COUNT    = 3'd0,
        REG_BIAS             = 3'd1,
        REG_SCALE_MULTIPLIER = 3'd2,
        REG_ROUNDING_TERM    = 3'd3,
        REG_SHIFT_AMOUNT     = 3'd4,
        REG_ZERO_POINT       = 3'd5,
        REG_CLAMP_MIN        = 3'd6,
        REG_CLAMP_MAX        = 3'd7
    } t_reg_idx;

    // one input row
    typedef struct packed {
        logic [BYTE_W-1:0] chan0;
        logic [BYTE_W-1:0] chan1;
        logic [BYTE_W-1:0] chan2;
        logic [BYTE_W-1:0] chan3;
        logic [BYTE_W-1:0] chan4;
        logic [BYTE_W-1:0] chan5;
        logic [BYTE_W-1:0] chan6;
        logic              last_row;
    } t_in_row;

    // one pooled result
    typedef struct packed {
        logic [BYTE_W-1:0] out0;
        logic [BYTE_W-1:0] out1;
        logic [BYTE_W-1:0] out2;
        logic [BYTE_W-1:0] out3;
        logic [BYTE_W-1:0] out4;
        logic [BYTE_W-1:0] out5;
        logic [BYTE_W-1:0] out6;
    } t_out_res;

    // configuration register file contents
    typedef struct packed {
        logic [CNT_W-1:0]          channel_count;
        logic signed [SUM_W-1:0]   bias;
        logic [SUM_W-1:0]          scale_multiplier;
        logic [RND_W-1:0]          rounding_term;
        logic [SHIFT_W-1:0]        shift_amount;
        logic signed [ZP_W-1:0]    zero_point;
        logic [BYTE_W-1:0]         clamp_min;
        logic [BYTE_W-1:0]         clamp_max;
    } t_cfg;

    typedef logic [SUM_W-1:0] t_sum;

    // finished pool handed from front to back
    typedef struct packed {
        logic [LANES-1:0]   lane_en;
        t_sum [LANES-1:0]   sums;
    } t_pool_item;

endpackage

`default_nettype wire

// ===== hdl/qgap_cfg.sv =====
// ----------------------------------------------------------------------------
// qgap_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgap_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [qgap_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [qgap_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output qgap_pkg::t_cfg                       o_cfg
);
    import qgap_pkg::*;

    t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count    <= CNT_W'(7);
            r_cfg.bias             <= '0;
            r_cfg.scale_multiplier <= SUM_W'(1);
            r_cfg.rounding_term    <= '0;
            r_cfg.shift_amount     <= '0;
            r_cfg.zero_point       <= '0;
            r_cfg.clamp_min        <= '0;
            r_cfg.clamp_max        <= BYTE_W'(255);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CHANNEL_COUNT:    r_cfg.channel_count    <= i_cfg_data[CNT_W-1:0];
                REG_BIAS:             r_cfg.bias             <= i_cfg_data[SUM_W-1:0];
                REG_SCALE_MULTIPLIER: r_cfg.scale_multiplier <= i_cfg_data[SUM_W-1:0];
                REG_ROUNDING_TERM:    r_cfg.rounding_term    <= i_cfg_data[RND_W-1:0];
                REG_SHIFT_AMOUNT:     r_cfg.shift_amount     <= i_cfg_data[SHIFT_W-1:0];
                REG_ZERO_POINT:       r_cfg.zero_point       <= i_cfg_data[ZP_W-1:0];
                REG_CLAMP_MIN:        r_cfg.clamp_min        <= i_cfg_data[BYTE_W-1:0];
                REG_CLAMP_MAX:        r_cfg.clamp_max        <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qgap_front.sv =====
// ----------------------------------------------------------------------------
// qgap_front
// Row intake: per-lane accumulation and hand-off of finished pools into a
// short queue toward the requantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgap_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire qgap_pkg::t_in_row          i_row,
    input  wire logic [qgap_pkg::CNT_W-1:0] i_channel_count,
    output logic                            o_item_valid,
    output qgap_pkg::t_pool_item            o_item,
    input  wire logic                       i_item_take
);
    import qgap_pkg::*;

    t_sum [LANES-1:0]  r_sum;
    t_sum [LANES-1:0]  n_sum;
    logic [BYTE_W-1:0] w_chan [LANES];
    logic [LANES-1:0]  w_lane_en;
    logic [CNT_W-1:0]  w_count;
    logic              w_accept;
    logic              w_enq;

    t_pool_item        r_mq [MQ_DEPTH];
    logic [MQ_AW-1:0]  r_wr;
    logic [MQ_AW-1:0]  r_rd;
    logic [MQ_AW:0]    r_cnt;

    assign w_chan[0] = i_row.chan0;
    assign w_chan[1] = i_row.chan1;
    assign w_chan[2] = i_row.chan2;
    assign w_chan[3] = i_row.chan3;
    assign w_chan[4] = i_row.chan4;
    assign w_chan[5] = i_row.chan5;
    assign w_chan[6] = i_row.chan6;

    // count above the lane limit acts as the limit
    assign w_count = (i_channel_count > CNT_W'(MAX_CHANNELS)) ?
                     CNT_W'(MAX_CHANNELS) : i_channel_count;

    assign w_accept = i_push && !o_full;
    assign w_enq    = w_accept && i_row.last_row;

    // lane accumulators
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_lane_en[l] = (CNT_W'(l) < w_count);
        assign n_sum[l]     = r_sum[l] + (w_lane_en[l] ? SUM_W'(w_chan[l]) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_accept) begin
            r_sum <= i_row.last_row ? '0 : n_sum;
        end
    end

    // pool queue storage
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mq[r_wr] <= '{lane_en: w_lane_en, sums: n_sum};
        end
    end

    // pool queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wr <= (r_wr == MQ_AW'(MQ_DEPTH - 1)) ? '0 : r_wr + MQ_AW'(1);
            end
            if (i_item_take) begin
                r_rd <= (r_rd == MQ_AW'(MQ_DEPTH - 1)) ? '0 : r_rd + MQ_AW'(1);
            end
            r_cnt <= r_cnt + (MQ_AW+1)'(w_enq) - (MQ_AW+1)'(i_item_take);
        end
    end

    assign o_full       = (r_cnt == (MQ_AW+1)'(MQ_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mq[r_rd];

endmodule

`default_nettype wire

// ===== hdl/qgap_back.sv =====
// ----------------------------------------------------------------------------
// qgap_back
// Requantizer: six-stage per-lane pipeline followed by the result queue.
// Issue is credit based, so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgap_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire qgap_pkg::t_cfg       i_cfg,
    input  wire logic                 i_item_valid,
    input  wire qgap_pkg::t_pool_item i_item,
    output logic                      o_item_take,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output qgap_pkg::t_out_res        o_res
);
    import qgap_pkg::*;

    logic [PIPE_N-1:0]  r_vld;
    logic [LANES-1:0]   r_en [PIPE_N];
    logic [BYTE_W-1:0]  w_byte [LANES];
    t_out_res           w_res;

    logic [OUT_AW:0]    r_used;
    logic [OUT_AW:0]    r_cnt;
    logic [OUT_AW-1:0]  r_wr;
    logic [OUT_AW-1:0]  r_rd;
    t_out_res           r_om [OUT_DEPTH];
    logic               w_issue;
    logic               w_pop;
    logic               w_wr;

    // issue only with room reserved in the result queue
    assign w_issue     = i_item_valid && (r_used < (OUT_AW+1)'(OUT_DEPTH));
    assign o_item_take = w_issue;
    assign w_pop       = i_pop && !o_empty;
    assign w_wr        = r_vld[PIPE_N-1];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_N-2:0], w_issue};
        end
    end

    // lane masks ride along
    always_ff @(posedge i_clk) begin
        r_en[0] <= i_item.lane_en;
        for (int k = 1; k < PIPE_N; k++) begin
            r_en[k] <= r_en[k-1];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [SUM_W-1:0]        r_acc;
        logic [SUM_W-1:0]        r_mag;
        logic [PROD_W-1:0]       r_prod;
        logic [PROD_W-1:0]       r_rnd;
        logic [PROD_W-1:0]       w_shr;
        logic [SUM_W-1:0]        r_low;
        logic signed [ZP_W-1:0]  r_v16;
        logic [3:0]              r_neg;
        logic signed [SUM_W-1:0] w_sgn;
        logic signed [ZP_W:0]    w_zsum;
        logic signed [ZP_W-1:0]  w_zsat;
        logic [BYTE_W-1:0]       w_u8;
        logic [BYTE_W-1:0]       w_hi;
        logic [BYTE_W-1:0]       w_lo;

        assign w_shr = r_rnd >> i_cfg.shift_amount;
        // sign bit of the item now in r_low
        assign w_sgn = r_neg[3] ? $signed(SUM_W'(0) - r_low) : $signed(r_low);

        // zero point add with int16 saturation, then byte range and clamps
        assign w_zsum = {r_v16[ZP_W-1], r_v16} +
                        {i_cfg.zero_point[ZP_W-1], i_cfg.zero_point};
        assign w_zsat = (w_zsum > $signed((ZP_W+1)'(32767)))  ? ZP_W'(32767)  :
                        (w_zsum < -$signed((ZP_W+1)'(32768))) ? ZP_W'(-32768) :
                        w_zsum[ZP_W-1:0];
        assign w_u8   = (w_zsat < 0)               ? '0 :
                        (w_zsat > ZP_W'(255))      ? BYTE_W'(255) :
                        w_zsat[BYTE_W-1:0];
        assign w_hi   = (w_u8 > i_cfg.clamp_max) ? i_cfg.clamp_max : w_u8;
        assign w_lo   = (w_hi < i_cfg.clamp_min) ? i_cfg.clamp_min : w_hi;
        assign w_byte[l] = r_en[PIPE_N-1][l] ? w_lo : '0;

        always_ff @(posedge i_clk) begin
            // bias
            r_acc    <= i_item.sums[l] + i_cfg.bias;
            // sign and magnitude
            r_neg[0] <= r_acc[SUM_W-1];
            r_mag    <= r_acc[SUM_W-1] ? (SUM_W'(0) - r_acc) : r_acc;
            // scale
            r_prod   <= PROD_W'(r_mag) * PROD_W'(i_cfg.scale_multiplier);
            // rounding
            r_rnd    <= r_prod + PROD_W'(i_cfg.rounding_term);
            // shift, keep low word
            r_low    <= w_shr[SUM_W-1:0];
            // sign restore and int16 saturation
            r_v16    <= (w_sgn > $signed(SUM_W'(32767)))  ? ZP_W'(32767)  :
                        (w_sgn < -$signed(SUM_W'(32768))) ? ZP_W'(-32768) :
                        w_sgn[ZP_W-1:0];
            r_neg[3:1] <= r_neg[2:0];
        end
    end

    assign w_res.out0 = w_byte[0];
    assign w_res.out1 = w_byte[1];
    assign w_res.out2 = w_byte[2];
    assign w_res.out3 = w_byte[3];
    assign w_res.out4 = w_byte[4];
    assign w_res.out5 = w_byte[5];
    assign w_res.out6 = w_byte[6];

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_om[r_wr] <= w_res;
        end
    end

    // result queue control and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : r_wr + OUT_AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == OUT_AW'(OUT_DEPTH - 1)) ? '0 : r_rd + OUT_AW'(1);
            end
            r_cnt  <= r_cnt + (OUT_AW+1)'(w_wr) - (OUT_AW+1)'(w_pop);
            r_used <= r_used + (OUT_AW+1)'(w_issue) - (OUT_AW+1)'(w_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_res   = r_om[r_rd];

    // credits cover exactly what is in flight plus what is stored
    a_credit_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OUT_AW+1)'($countones(r_vld)) + r_cnt == r_used)
        else $error("credit count out of step with pipeline and queue");

    a_credit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (r_cnt != (OUT_AW+1)'(OUT_DEPTH)) || w_pop)
        else $error("result queue written while full");

    a_issue_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_vld[0])
        else $error("issued item did not enter the pipeline");

endmodule

`default_nettype wire

// ===== hdl/quantized_global_avg_pool.sv =====
// ----------------------------------------------------------------------------
// quantized_global_avg_pool
// Global average pooling of seven unsigned byte lanes with requantization
// to bytes.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  row in   | push / full            | i_row  (chan0..chan6, last_row)
//  result   | empty / pop            | o_res  (out0..out6)
//  config   | i_cfg_valid / ready    | i_cfg_index, i_cfg_data
//
// One row is accepted per cycle while full is low; accumulation is a single
// add per lane. A last row's result passes from the pool queue through the
// requantizer pipeline stages (bias, magnitude, 32x32 multiply, rounding add,
// shift, saturation), the last of which writes the result queue; issue from
// the pool queue waits for a free result queue credit.
// Reset is synchronous and clears sums, queues and registers to defaults.
// Up to eight results are held; with the consumer stalled, rows keep being
// accepted until the two-entry pool queue fills on further last rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quantized_global_avg_pool (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire qgap_pkg::t_in_row               i_row,
    output logic                                 empty,
    input  wire logic                            pop,
    output qgap_pkg::t_out_res                   o_res,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [qgap_pkg::REG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [qgap_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qgap_pkg::*;

    t_cfg       w_cfg;
    t_pool_item w_item;
    logic       w_item_valid;
    logic       w_item_take;

    // register file
    qgap_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // accumulation and pool queue
    qgap_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_row           (i_row),
        .i_channel_count (w_cfg.channel_count),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item),
        .i_item_take     (w_item_take)
    );

    // requantizer and result queue
    qgap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire
